// ===== src/hrlp_pkg.sv =====
// shared types, widths, codes and tables of the request line parser
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

  // widths of the channel fields
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int MCODE_W = 4;
  localparam int VER_W   = 16;
  localparam int USED_W  = 16;
  localparam int ERR_W   = 3;

  // default width of the saturating byte counter
  localparam int COUNT_WIDTH_DEF = 16;

  // limit register widths
  localparam int ML_W = 8;
  localparam int UL_W = 13;
  localparam int PL_W = 7;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_METHOD_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_URI_LIMIT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROTO_LIMIT  = 2'd2;

  localparam logic [ML_W-1:0] METHOD_LIMIT_RST = 8'd128;
  localparam logic [UL_W-1:0] URI_LIMIT_RST    = 13'd2048;
  localparam logic [PL_W-1:0] PROTO_LIMIT_RST  = 7'd64;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_URI   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_METHOD = 3'd1;
  localparam logic [ERR_W-1:0] ERR_URI    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_PROTO  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_END    = 3'd4;

  localparam logic [MCODE_W-1:0] MCODE_UNKNOWN = 4'd8;

  // characters
  localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  // method names, character 0 first, zero padded to eight
  localparam logic [0:7][BYTE_W-1:0] METH_NAME [8] = '{
    {"OPTIONS", 8'h00},
    {"GET", 40'h0},
    {"HEAD", 32'h0},
    {"POST", 32'h0},
    {"PUT", 40'h0},
    {"DELETE", 16'h0},
    {"TRACE", 24'h0},
    {"CONNECT", 8'h00}
  };
  localparam logic [3:0] METH_LEN [8] = '{
    4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
  };

  localparam logic [0:4][BYTE_W-1:0] PROTO_PREFIX = "HTTP/";

  typedef struct packed {
    logic [ML_W-1:0] method_limit;
    logic [UL_W-1:0] uri_limit;
    logic [PL_W-1:0] proto_limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [BYTE_W-1:0]       uri_byte;
    logic [MCODE_W-1:0]      method_code;
    logic signed [VER_W-1:0] version_major;
    logic signed [VER_W-1:0] version_minor;
    logic [USED_W-1:0]       bytes_used;
    logic [ERR_W-1:0]        error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== src/hrlp_if.sv =====
// byte and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface hrlp_in_if import hrlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              data_end;

  modport source (output valid, byte_value, data_end, input ready);
  modport sink (input valid, byte_value, data_end, output ready);
endinterface

interface hrlp_out_if import hrlp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [BYTE_W-1:0]       uri_byte;
  logic [MCODE_W-1:0]      method_code;
  logic signed [VER_W-1:0] version_major;
  logic signed [VER_W-1:0] version_minor;
  logic [USED_W-1:0]       bytes_used;
  logic [ERR_W-1:0]        error_code;

  modport source (output valid, kind, uri_byte, method_code, version_major,
                  version_minor, bytes_used, error_code, input ready);
  modport sink (input valid, kind, uri_byte, method_code, version_major,
                version_minor, bytes_used, error_code, output ready);
endinterface

`default_nettype wire

// ===== src/hrlp_cfg.sv =====
// limit registers behind the apb configuration port
`timescale 1ns / 1ps
`default_nettype none

module hrlp_cfg import hrlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method_limit <= METHOD_LIMIT_RST;
      cfg.uri_limit    <= URI_LIMIT_RST;
      cfg.proto_limit  <= PROTO_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_METHOD_LIMIT: cfg.method_limit <= pwdata[ML_W-1:0];
        REG_URI_LIMIT:    cfg.uri_limit <= pwdata[UL_W-1:0];
        REG_PROTO_LIMIT:  cfg.proto_limit <= pwdata[PL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_METHOD_LIMIT: prdata = APB_DATA_W'(cfg.method_limit);
      REG_URI_LIMIT:    prdata = APB_DATA_W'(cfg.uri_limit);
      REG_PROTO_LIMIT:  prdata = APB_DATA_W'(cfg.proto_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/hrlp_parse.sv =====
// line state registers and the per-byte parse step
`timescale 1ns / 1ps
`default_nettype none

module hrlp_parse import hrlp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              data_end,
  input  cfg_t              cfg,
  output logic              res_valid,
  output res_t              res
);

  localparam logic [2:0] PH_METHOD   = 3'd0;
  localparam logic [2:0] PH_SKIP     = 3'd1;
  localparam logic [2:0] PH_URI      = 3'd2;
  localparam logic [2:0] PH_PROTO    = 3'd3;
  localparam logic [2:0] PH_AFTER_CR = 3'd4;

  localparam logic [3:0] VS_P0        = 4'd0;
  localparam logic [3:0] VS_P1        = 4'd1;
  localparam logic [3:0] VS_P2        = 4'd2;
  localparam logic [3:0] VS_P3        = 4'd3;
  localparam logic [3:0] VS_P4        = 4'd4;
  localparam logic [3:0] VS_MAJ_BLANK = 4'd5;
  localparam logic [3:0] VS_MAJ_SIGN  = 4'd6;
  localparam logic [3:0] VS_MAJ_DIG   = 4'd7;
  localparam logic [3:0] VS_MIN_BLANK = 4'd8;
  localparam logic [3:0] VS_MIN_SIGN  = 4'd9;
  localparam logic [3:0] VS_MIN_DIG   = 4'd10;
  localparam logic [3:0] VS_STOP      = 4'd11;

  localparam logic [VER_W-1:0] MAG_CAP = VER_W'(1) << (VER_W - 1);
  localparam logic [VER_W-1:0] MAG_MAX = MAG_CAP - VER_W'(1);

  function automatic logic [VER_W-1:0] sat_digit(input logic [VER_W-1:0] mag,
                                                 input logic [3:0] d);
    logic [VER_W+3:0] t;
    t = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {{VER_W{1'b0}}, d};
    return (t > {4'b0, MAG_CAP}) ? MAG_CAP : t[VER_W-1:0];
  endfunction

  function automatic logic [VER_W-1:0] ver_out(input logic set, input logic neg,
                                               input logic [VER_W-1:0] mag);
    logic [VER_W-1:0] v;
    if (!set) v = '1;
    else if (neg) v = '0 - mag;
    else if (mag > MAG_MAX) v = MAG_MAX;
    else v = mag;
    return v;
  endfunction

  logic [2:0]             phase, phase_next, ph;
  logic [ML_W-1:0]        mlen, mlen_next, mlen_cur;
  logic [7:0]             cand, cand_next;
  logic [MCODE_W-1:0]     mcode, mcode_next;
  logic [UL_W-1:0]        ulen, ulen_next;
  logic [PL_W-1:0]        plen, plen_next;
  logic [3:0]             vstep, vstep_next;
  logic [VER_W-1:0]       maj_mag, maj_mag_next, min_mag, min_mag_next;
  logic                   maj_neg, maj_neg_next, min_neg, min_neg_next;
  logic                   maj_set, maj_set_next, min_set, min_set_next;
  logic [COUNT_WIDTH-1:0] bcount, bcount_next;
  logic [COUNT_WIDTH+USED_W-1:0] bcount_ext;

  logic       line_new, clear, is_sp, dig, blank, sign, minus;
  logic [3:0] digit;
  logic [7:0] kill;

  assign line_new = (phase == PH_AFTER_CR);
  assign ph       = line_new ? PH_METHOD : phase;
  assign mlen_cur = line_new ? '0 : mlen;
  assign is_sp    = (byte_value == CH_SP);
  assign dig      = (byte_value >= CH_0) && (byte_value <= CH_9);
  assign blank    = is_sp || ((byte_value >= CH_HT) && (byte_value <= CH_CR));
  assign minus    = (byte_value == CH_MINUS);
  assign sign     = minus || (byte_value == CH_PLUS);
  assign digit    = byte_value[3:0];

  // names that drop out with this method byte
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      kill[k] = (mlen_cur >= ML_W'(METH_LEN[k])) ||
                (METH_NAME[k][mlen_cur[2:0]] != byte_value);
    end
  end

  always_comb begin
    // a byte after cr starts from a fresh line
    phase_next   = ph;
    mlen_next    = line_new ? '0 : mlen;
    cand_next    = line_new ? '1 : cand;
    mcode_next   = line_new ? MCODE_UNKNOWN : mcode;
    ulen_next    = line_new ? '0 : ulen;
    plen_next    = line_new ? '0 : plen;
    vstep_next   = line_new ? VS_P0 : vstep;
    maj_mag_next = line_new ? '0 : maj_mag;
    min_mag_next = line_new ? '0 : min_mag;
    maj_neg_next = line_new ? 1'b0 : maj_neg;
    min_neg_next = line_new ? 1'b0 : min_neg;
    maj_set_next = line_new ? 1'b0 : maj_set;
    min_set_next = line_new ? 1'b0 : min_set;
    bcount_next  = line_new ? '0 : bcount;
    bcount_ext   = '0;
    clear        = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    if (line_new && (data_end || (byte_value == CH_LF))) begin
      // lf after cr, or end of data after a line: absorbed
    end else if (data_end) begin
      clear          = 1'b1;
      res_valid      = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_END;
    end else begin
      if (bcount_next != '1) bcount_next = bcount_next + 1'b1;
      unique case (ph) inside
        PH_METHOD: begin
          if (is_sp) begin
            for (int k = 0; k < 8; k++) begin
              if (cand_next[k] && (mlen_next == ML_W'(METH_LEN[k]))) begin
                mcode_next = MCODE_W'(k);
              end
            end
            phase_next = PH_SKIP;
          end else begin
            cand_next = cand_next & ~kill;
            mlen_next = mlen_next + 1'b1;
            if (mlen_next >= cfg.method_limit) begin
              clear          = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_METHOD;
            end
          end
        end
        PH_SKIP, PH_URI: begin
          if (is_sp) begin
            if (ph == PH_URI) phase_next = PH_PROTO;
          end else begin
            phase_next = PH_URI;
            ulen_next  = ulen + 1'b1;
            res_valid  = 1'b1;
            if (ulen_next >= cfg.uri_limit) begin
              clear          = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_URI;
            end else begin
              res.kind     = KIND_URI;
              res.uri_byte = byte_value;
            end
          end
        end
        PH_PROTO: begin
          if (byte_value == CH_CR) begin
            bcount_ext        = {{USED_W{1'b0}}, bcount_next};
            res_valid         = 1'b1;
            res.kind          = KIND_LINE;
            res.method_code   = mcode;
            res.version_major = ver_out(maj_set, maj_neg, maj_mag);
            res.version_minor = ver_out(min_set, min_neg, min_mag);
            res.bytes_used    = bcount_ext[USED_W-1:0];
            phase_next        = PH_AFTER_CR;
          end else begin
            unique case (vstep) inside
              VS_P0, VS_P1, VS_P2, VS_P3, VS_P4: begin
                vstep_next = (byte_value == PROTO_PREFIX[vstep[2:0]]) ?
                             vstep + 4'd1 : VS_STOP;
              end
              VS_MAJ_BLANK, VS_MIN_BLANK: begin
                if (!blank) begin
                  if (sign) begin
                    if (vstep == VS_MAJ_BLANK) maj_neg_next = minus;
                    else min_neg_next = minus;
                    vstep_next = vstep + 4'd1;
                  end else if (dig) begin
                    if (vstep == VS_MAJ_BLANK) begin
                      maj_mag_next = sat_digit('0, digit);
                      maj_set_next = 1'b1;
                    end else begin
                      min_mag_next = sat_digit('0, digit);
                      min_set_next = 1'b1;
                    end
                    vstep_next = vstep + 4'd2;
                  end else begin
                    vstep_next = VS_STOP;
                  end
                end
              end
              VS_MAJ_SIGN, VS_MIN_SIGN: begin
                if (!dig) begin
                  vstep_next = VS_STOP;
                end else begin
                  if (vstep == VS_MAJ_SIGN) begin
                    maj_mag_next = sat_digit('0, digit);
                    maj_set_next = 1'b1;
                  end else begin
                    min_mag_next = sat_digit('0, digit);
                    min_set_next = 1'b1;
                  end
                  vstep_next = vstep + 4'd1;
                end
              end
              VS_MAJ_DIG: begin
                if (dig) maj_mag_next = sat_digit(maj_mag, digit);
                else vstep_next = (byte_value == CH_DOT) ? VS_MIN_BLANK : VS_STOP;
              end
              VS_MIN_DIG: begin
                if (dig) min_mag_next = sat_digit(min_mag, digit);
                else vstep_next = VS_STOP;
              end
              default: ;
            endcase
            plen_next = plen + 1'b1;
            if (plen_next >= cfg.proto_limit) begin
              clear          = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_PROTO;
            end
          end
        end
        default: ;
      endcase
    end

    // errors and end of data drop the whole line
    if (clear) begin
      phase_next   = PH_METHOD;
      mlen_next    = '0;
      cand_next    = '1;
      mcode_next   = MCODE_UNKNOWN;
      ulen_next    = '0;
      plen_next    = '0;
      vstep_next   = VS_P0;
      maj_mag_next = '0;
      min_mag_next = '0;
      maj_neg_next = 1'b0;
      min_neg_next = 1'b0;
      maj_set_next = 1'b0;
      min_set_next = 1'b0;
      bcount_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_METHOD;
      mlen    <= '0;
      cand    <= '1;
      mcode   <= MCODE_UNKNOWN;
      ulen    <= '0;
      plen    <= '0;
      vstep   <= VS_P0;
      maj_mag <= '0;
      min_mag <= '0;
      maj_neg <= 1'b0;
      min_neg <= 1'b0;
      maj_set <= 1'b0;
      min_set <= 1'b0;
      bcount  <= '0;
    end else if (take) begin
      phase   <= phase_next;
      mlen    <= mlen_next;
      cand    <= cand_next;
      mcode   <= mcode_next;
      ulen    <= ulen_next;
      plen    <= plen_next;
      vstep   <= vstep_next;
      maj_mag <= maj_mag_next;
      min_mag <= min_mag_next;
      maj_neg <= maj_neg_next;
      min_neg <= min_neg_next;
      maj_set <= maj_set_next;
      min_set <= min_set_next;
      bcount  <= bcount_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/hrlp_outq.sv =====
// two-word result queue between the parse step and the result channel
`timescale 1ns / 1ps
`default_nettype none

module hrlp_outq import hrlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic head_valid,
  input  logic pop,
  output res_t head
);

  res_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/http_request_line_parser.sv =====
// http request line parser top level: channels, limit registers, parse step
// takes one byte per cycle unless the queue is full; handled in the cycle taken
// a result word is registered in the queue and leaves it on the result channel
// a two-word result queue keeps bytes flowing while one result waits
// rst is synchronous: limits go to 128/2048/64 and the line restarts
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_parser import hrlp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  hrlp_in_if.sink               byte_ch,
  hrlp_out_if.source            result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  res_t res;
  res_t head;
  logic res_valid;
  logic take;
  logic push;
  logic pop;
  logic full;
  logic head_valid;

  assign byte_ch.ready = !full;
  assign take          = byte_ch.valid && !full;
  assign push          = take && res_valid;
  assign pop           = head_valid && result_ch.ready;

  hrlp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrlp_parse #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (byte_ch.byte_value),
    .data_end   (byte_ch.data_end),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrlp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .full       (full),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  assign result_ch.valid         = head_valid;
  assign result_ch.kind          = head.kind;
  assign result_ch.uri_byte      = head.uri_byte;
  assign result_ch.method_code   = head.method_code;
  assign result_ch.version_major = head.version_major;
  assign result_ch.version_minor = head.version_minor;
  assign result_ch.bytes_used    = head.bytes_used;
  assign result_ch.error_code    = head.error_code;

  // input only stalls while results are waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !byte_ch.ready |-> result_ch.valid)
    else $error("byte channel stalled with no result pending");

  // after a push, the result channel holds a valid word next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> result_ch.valid)
    else $error("pushed result word not visible");

  // end of data never yields a uri byte or a parsed line
  a_end_is_error: assert property (@(posedge clk) disable iff (rst)
    push && byte_ch.data_end |-> res.kind == KIND_ERROR && res.error_code == ERR_END)
    else $error("end of data produced a non-error word");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.kind == KIND_ERROR |-> result_ch.error_code != ERR_NONE)
    else $error("error word without error code");

endmodule

`default_nettype wire
